/* hdl/lu_linear_solver_assert.svh */
// assertion macros shared by the solver rtl
// depends on nothing; included by files that carry concurrent checks
`ifndef LU_LINEAR_SOLVER_ASSERT_SVH
`define LU_LINEAR_SOLVER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LU_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lu check failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define LU_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lu check failed: next-cycle implication");

`endif

/* hdl/lu_pkg.sv */
// shared constants and helpers for the lu solver
// depends on nothing
`timescale 1ns / 1ps

package lu_pkg;

    localparam int DATA_W   = 32;
    localparam int CNT_W    = 4;
    localparam int LIN_W    = 8;
    localparam int ACC_W    = 70;
    localparam int CFG_AW   = 3;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    // row-major position at stride n
    function automatic logic [LIN_W-1:0] lin(input logic [CNT_W-1:0] row,
                                             input logic [CNT_W-1:0] col,
                                             input logic [CNT_W-1:0] n);
        lin = LIN_W'(row) * LIN_W'(n) + LIN_W'(col);
    endfunction

endpackage

/* hdl/lu_div_cell.sv */
// one restoring-division cell: settles one quotient bit and hands on
// depends on nothing
`timescale 1ns / 1ps

module lu_div_cell #(
    parameter int DIV_W = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [31:0]      in_rem,
    input  logic [DIV_W-1:0] in_dq,
    input  logic [31:0]      in_den,
    input  logic             in_neg,
    output logic             out_valid,
    output logic [31:0]      out_rem,
    output logic [DIV_W-1:0] out_dq,
    output logic [31:0]      out_den,
    output logic             out_neg
);

    logic             valid_reg;
    logic [31:0]      rem_reg;
    logic [DIV_W-1:0] dq_reg;
    logic [31:0]      den_reg;
    logic             neg_reg;

    logic [33:0]      trial;
    logic             ge;
    logic [31:0]      rem_next;
    logic [DIV_W-1:0] dq_next;

    always_comb
    begin
        trial    = {1'b0, in_rem, in_dq[DIV_W-1]} - {2'b00, in_den};
        ge       = !trial[33];
        rem_next = ge ? trial[31:0] : {in_rem[30:0], in_dq[DIV_W-1]};
        dq_next  = {in_dq[DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        den_reg <= in_den;
        neg_reg <= in_neg;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_dq    = dq_reg;
    assign out_den   = den_reg;
    assign out_neg   = neg_reg;

endmodule

/* hdl/lu_div_chain.sv */
// fixed-point divider built as a row of division cells, one per quotient bit
// depends on lu_pkg and lu_div_cell
`timescale 1ns / 1ps

module lu_div_chain #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [lu_pkg::DATA_W-1:0]  num,
    input  logic signed [lu_pkg::DATA_W-1:0]  den,
    output logic                              done,
    output logic signed [lu_pkg::DATA_W-1:0]  quotient
);

    localparam int DIV_W = lu_pkg::DATA_W + FRAC_BITS;

    logic             v_w   [0:DIV_W];
    logic [31:0]      rem_w [0:DIV_W];
    logic [DIV_W-1:0] dq_w  [0:DIV_W];
    logic [31:0]      den_w [0:DIV_W];
    logic             neg_w [0:DIV_W];

    logic [31:0] num_mag;
    logic [31:0] den_mag;

    logic                             done_reg;
    logic signed [lu_pkg::DATA_W-1:0] quotient_reg;
    logic [DIV_W-1:0]                 q_mag;
    logic                             upper_set;
    logic signed [lu_pkg::DATA_W-1:0] quotient_next;

    always_comb
    begin
        num_mag = num[31] ? (~num + 32'd1) : num;
        den_mag = den[31] ? (~den + 32'd1) : den;
    end

    assign v_w[0]   = start;
    assign rem_w[0] = '0;
    assign dq_w[0]  = {num_mag, FRAC_BITS'(0)};
    assign den_w[0] = den_mag;
    assign neg_w[0] = num[31] ^ den[31];

    for (genvar g = 0; g < DIV_W; g++)
    begin : g_cell
        lu_div_cell #(.DIV_W(DIV_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_w[g]),
            .in_rem    (rem_w[g]),
            .in_dq     (dq_w[g]),
            .in_den    (den_w[g]),
            .in_neg    (neg_w[g]),
            .out_valid (v_w[g+1]),
            .out_rem   (rem_w[g+1]),
            .out_dq    (dq_w[g+1]),
            .out_den   (den_w[g+1]),
            .out_neg   (neg_w[g+1])
        );
    end

    // saturate the truncated magnitude back into signed q format
    always_comb
    begin
        q_mag     = dq_w[DIV_W];
        upper_set = |q_mag[DIV_W-1:32];
        if (neg_w[DIV_W])
        begin
            if (upper_set || (q_mag[31] && (|q_mag[30:0])))
                quotient_next = lu_pkg::Q_MIN;
            else
                quotient_next = ~q_mag[31:0] + 32'd1;
        end
        else
        begin
            if (upper_set || q_mag[31])
                quotient_next = lu_pkg::Q_MAX;
            else
                quotient_next = q_mag[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v_w[DIV_W];
        end
    end

    always_ff @(posedge clk)
    begin
        quotient_reg <= quotient_next;
    end

    assign done     = done_reg;
    assign quotient = quotient_reg;

endmodule

/* hdl/lu_linear_solver.sv */
// top level of the doolittle lu solver: loading, sequencing, stores, output
// depends on lu_pkg, lu_div_chain and lu_linear_solver_assert.svh
`timescale 1ns / 1ps
//
//  channel    direction  handshake                     payload
//  item       in         item_valid / item_stall       kind, value
//  solution   out        solution_valid / solution_stall
//                                                      solution_value, solution_index,
//                                                      last, singular
//  config     in         apb write, psel/penable       size_in_use at byte address 0
//
//  loading accepts one transaction per cycle while item_stall is low
//  each multiply-accumulate term of the solve passes the read, multiply and accumulate states;
//  there are about n^3/3 + n^2/2 terms, and each of the n(n+1)/2 divisions runs through the
//  division cell row; the single shared mac serves all terms; then n output transactions
//  item_stall is high from the last right-hand transaction until the last result is
//  loaded into the output register; solution_stall holds that register and the emit states
//  reset clears control state alone; stores hold nothing meaningful until loaded

module lu_linear_solver #(
    parameter int MAX_SIZE  = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // item channel
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic                              kind,
    input  logic signed [31:0]                value,
    // solution channel
    output logic                              solution_valid,
    input  logic                              solution_stall,
    output logic signed [31:0]                solution_value,
    output logic [2:0]                        solution_index,
    output logic                              last,
    output logic                              singular,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lu_pkg::CFG_AW-1:0]         paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int CW    = lu_pkg::CNT_W;
    localparam int LW    = lu_pkg::LIN_W;
    localparam int AccW  = lu_pkg::ACC_W;

    typedef enum logic [10:0] {
        S_LOAD    = 11'b000_0000_0001,
        S_START   = 11'b000_0000_0010,
        S_INIT    = 11'b000_0000_0100,
        S_T_RD    = 11'b000_0000_1000,
        S_T_MUL   = 11'b000_0001_0000,
        S_T_ACC   = 11'b000_0010_0000,
        S_FIN     = 11'b000_0100_0000,
        S_DIV     = 11'b000_1000_0000,
        S_NEXT    = 11'b001_0000_0000,
        S_EMIT_RD = 11'b010_0000_0000,
        S_EMIT_WR = 11'b100_0000_0000
    } state_t;

    // which dot product family is running
    typedef enum logic [3:0] {
        PH_U = 4'b0001,   // upper row
        PH_L = 4'b0010,   // lower column, divided by pivot
        PH_F = 4'b0100,   // forward substitution
        PH_B = 4'b1000    // back substitution, divided by diagonal
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg;

    logic [3:0]    size_reg;
    logic [CW-1:0] n_cur;
    logic [CW-1:0] i_reg, k_reg, j_reg, e_reg;
    logic [LW-1:0] matrix_count_reg;
    logic [CW-1:0] rhs_count_reg;

    logic signed [AccW-1:0] acc_reg;
    logic signed [63:0]     prod_reg;
    logic signed [31:0]     pivot_reg;
    logic                   singular_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_value_reg;
    logic [2:0]         out_index_reg;
    logic               out_last_reg;
    logic               out_singular_reg;

    // stores
    logic signed [31:0] factor_mem [0:DEPTH-1];
    logic signed [31:0] rhs_mem    [0:MAX_SIZE-1];
    logic signed [31:0] sol_mem    [0:MAX_SIZE-1];
    logic signed [31:0] fa_rdata_reg, fb_rdata_reg, rhs_rdata_reg, sol_rdata_reg;

    logic          cfg_wr;
    logic          item_acc;
    logic [LW-1:0] nn;
    logic          mat_full;
    logic          load_mat, load_rhs, go;

    logic [LW-1:0] dest_lin;
    logic [LW-1:0] fa_lin, fb_lin;
    logic [CW-1:0] sol_ridx;

    logic signed [AccW-1:0] acc_sh;
    logic [AccW-32:0]       acc_hi;
    logic signed [31:0]     q_val;
    logic signed [31:0]     b_op;

    logic          fwe;
    logic [AW-1:0] fwaddr;
    logic signed [31:0] fwdata;
    logic          swe;
    logic signed [31:0] swdata;

    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_q;

    logic is_div_phase;
    logic pivot_zero;
    logic terms_empty;
    logic terms_done;
    logic out_free;
    logic emit_last;

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {28'd0, size_reg} : 32'd0;

    // effective order, zero acts as one and large values clamp
    always_comb
    begin
        if (size_reg == 4'd0)
            n_cur = 4'd1;
        else if (32'(size_reg) > MAX_SIZE)
            n_cur = CW'(MAX_SIZE);
        else
            n_cur = size_reg;
    end

    // ---------------------------------------------------------------- load decode
    assign item_stall = (state_reg != S_LOAD);
    assign item_acc   = item_valid && !item_stall;
    assign nn         = LW'(n_cur) * LW'(n_cur);
    assign mat_full   = (matrix_count_reg >= nn);
    assign load_mat   = item_acc && !kind && !mat_full;
    assign load_rhs   = item_acc && kind && mat_full && (rhs_count_reg < n_cur);
    // a right-hand transaction that completes (or finds complete) the vector starts the solve
    assign go = item_acc && kind && mat_full &&
                (({1'b0, rhs_count_reg} + 5'd1) >= {1'b0, n_cur});

    // ---------------------------------------------------------------- addressing
    assign is_div_phase = (phase_reg == PH_L) || (phase_reg == PH_B);
    assign dest_lin = (phase_reg == PH_U) ? lu_pkg::lin(i_reg, k_reg, n_cur)
                                          : lu_pkg::lin(k_reg, i_reg, n_cur);

    always_comb
    begin
        if (state_reg == S_START)
            fa_lin = (phase_reg == PH_B) ? lu_pkg::lin(i_reg, i_reg, n_cur) : dest_lin;
        else if (phase_reg == PH_L)
            fa_lin = lu_pkg::lin(k_reg, j_reg, n_cur);
        else
            fa_lin = lu_pkg::lin(i_reg, j_reg, n_cur);
        fb_lin = (phase_reg == PH_U) ? lu_pkg::lin(j_reg, k_reg, n_cur)
                                     : lu_pkg::lin(j_reg, i_reg, n_cur);
        if ((state_reg == S_EMIT_RD) || (state_reg == S_EMIT_WR))
            sol_ridx = e_reg;
        else if (state_reg == S_START)
            sol_ridx = i_reg;
        else
            sol_ridx = j_reg;
    end

    // ---------------------------------------------------------------- arithmetic
    // floor shift of the wide sum, then saturate to 32 bits
    always_comb
    begin
        acc_sh = acc_reg >>> FRAC_BITS;
        acc_hi = acc_sh[AccW-1:31];
        if ((&acc_hi) || !(|acc_hi))
            q_val = acc_sh[31:0];
        else
            q_val = acc_sh[AccW-1] ? lu_pkg::Q_MIN : lu_pkg::Q_MAX;
    end

    assign b_op = ((phase_reg == PH_F) || (phase_reg == PH_B)) ? sol_rdata_reg : fb_rdata_reg;

    assign pivot_zero  = (phase_reg == PH_U) && (k_reg == i_reg) && (q_val == 32'sd0);
    assign terms_empty = (phase_reg == PH_B) ? (CW'(i_reg + 4'd1) == n_cur) : (i_reg == 4'd0);
    assign terms_done  = (phase_reg == PH_B) ? (CW'(j_reg + 4'd1) == n_cur)
                                             : (CW'(j_reg + 4'd1) == i_reg);
    assign div_start   = (state_reg == S_FIN) && is_div_phase;

    lu_div_chain #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (q_val),
        .den      (pivot_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---------------------------------------------------------------- store writes
    always_comb
    begin
        fwe    = 1'b0;
        fwaddr = AW'(dest_lin);
        fwdata = q_val;
        swe    = 1'b0;
        swdata = q_val;
        if (load_mat)
        begin
            fwe    = 1'b1;
            fwaddr = AW'(matrix_count_reg);
            fwdata = value;
        end
        else if ((state_reg == S_FIN) && (phase_reg == PH_U))
        begin
            fwe = 1'b1;
        end
        else if ((state_reg == S_DIV) && div_done && (phase_reg == PH_L))
        begin
            fwe    = 1'b1;
            fwdata = div_q;
        end
        if ((state_reg == S_FIN) && (phase_reg == PH_F))
            swe = 1'b1;
        else if ((state_reg == S_DIV) && div_done && (phase_reg == PH_B))
        begin
            swe    = 1'b1;
            swdata = div_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fwe)
            factor_mem[fwaddr] <= fwdata;
        if (load_rhs)
            rhs_mem[IW'(rhs_count_reg)] <= value;
        if (swe)
            sol_mem[IW'(i_reg)] <= swdata;
        fa_rdata_reg  <= factor_mem[AW'(fa_lin)];
        fb_rdata_reg  <= factor_mem[AW'(fb_lin)];
        rhs_rdata_reg <= rhs_mem[IW'(i_reg)];
        sol_rdata_reg <= sol_mem[IW'(sol_ridx)];
    end

    // ---------------------------------------------------------------- sequencer
    assign out_free  = !out_valid_reg || !solution_stall;
    assign emit_last = (CW'(e_reg + 4'd1) == n_cur);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:    if (go) state_next = S_START;
            S_START:   state_next = S_INIT;
            S_INIT:    state_next = terms_empty ? S_FIN : S_T_RD;
            S_T_RD:    state_next = S_T_MUL;
            S_T_MUL:   state_next = S_T_ACC;
            S_T_ACC:   state_next = terms_done ? S_FIN : S_T_RD;
            S_FIN:
            begin
                if (is_div_phase)
                    state_next = S_DIV;
                else if (pivot_zero)
                    state_next = S_EMIT_RD;
                else
                    state_next = S_NEXT;
            end
            S_DIV:     if (div_done) state_next = S_NEXT;
            S_NEXT:
            begin
                if ((phase_reg == PH_B) && (i_reg == 4'd0))
                    state_next = S_EMIT_RD;
                else
                    state_next = S_START;
            end
            S_EMIT_RD: state_next = S_EMIT_WR;
            S_EMIT_WR:
            begin
                if (out_free)
                    state_next = emit_last ? S_LOAD : S_EMIT_RD;
            end
            default:   state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            phase_reg        <= PH_U;
            size_reg         <= 4'd8;
            i_reg            <= '0;
            k_reg            <= '0;
            j_reg            <= '0;
            e_reg            <= '0;
            matrix_count_reg <= '0;
            rhs_count_reg    <= '0;
            singular_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
                size_reg <= pwdata[3:0];

            if (load_mat)
                matrix_count_reg <= matrix_count_reg + LW'(1);
            // the starting transaction clears the count below instead
            if (load_rhs && !go)
                rhs_count_reg <= rhs_count_reg + CW'(1);

            // output register drains independently of the sequencer
            if ((state_reg == S_EMIT_WR) && out_free)
                out_valid_reg <= 1'b1;
            else if (!solution_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_LOAD:
                begin
                    if (go)
                    begin
                        matrix_count_reg <= '0;
                        rhs_count_reg    <= '0;
                        phase_reg        <= PH_U;
                        i_reg            <= '0;
                        k_reg            <= '0;
                        singular_reg     <= 1'b0;
                    end
                end
                S_INIT:
                begin
                    j_reg <= (phase_reg == PH_B) ? CW'(i_reg + 4'd1) : '0;
                end
                S_T_ACC:
                begin
                    j_reg <= j_reg + CW'(1);
                end
                S_FIN:
                begin
                    if (pivot_zero)
                    begin
                        singular_reg <= 1'b1;
                        e_reg        <= '0;
                    end
                end
                S_NEXT:
                begin
                    unique case (phase_reg)
                        PH_U:
                        begin
                            if (CW'(k_reg + 4'd1) == n_cur)
                            begin
                                if (CW'(i_reg + 4'd1) == n_cur)
                                begin
                                    phase_reg <= PH_F;
                                    i_reg     <= '0;
                                end
                                else
                                begin
                                    phase_reg <= PH_L;
                                    k_reg     <= CW'(i_reg + 4'd1);
                                end
                            end
                            else
                                k_reg <= k_reg + CW'(1);
                        end
                        PH_L:
                        begin
                            if (CW'(k_reg + 4'd1) == n_cur)
                            begin
                                phase_reg <= PH_U;
                                i_reg     <= i_reg + CW'(1);
                                k_reg     <= i_reg + CW'(1);
                            end
                            else
                                k_reg <= k_reg + CW'(1);
                        end
                        PH_F:
                        begin
                            if (CW'(i_reg + 4'd1) == n_cur)
                                phase_reg <= PH_B;
                            else
                                i_reg <= i_reg + CW'(1);
                        end
                        PH_B:
                        begin
                            if (i_reg == 4'd0)
                                e_reg <= '0;
                            else
                                i_reg <= i_reg - CW'(1);
                        end
                        default: phase_reg <= PH_U;
                    endcase
                end
                S_EMIT_WR:
                begin
                    if (out_free)
                        e_reg <= e_reg + CW'(1);
                end
                default:
                begin
                    i_reg <= i_reg;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_INIT)
        begin
            // minuend scaled to double fraction width
            unique case (phase_reg)
                PH_F:    acc_reg <= AccW'(rhs_rdata_reg) <<< FRAC_BITS;
                PH_B:    acc_reg <= AccW'(sol_rdata_reg) <<< FRAC_BITS;
                default: acc_reg <= AccW'(fa_rdata_reg) <<< FRAC_BITS;
            endcase
            if (phase_reg == PH_B)
                pivot_reg <= fa_rdata_reg;
        end
        else if (state_reg == S_T_ACC)
            acc_reg <= acc_reg - AccW'(prod_reg);

        if (state_reg == S_T_MUL)
            prod_reg <= 64'(fa_rdata_reg) * 64'(b_op);

        // upper diagonal element becomes the pivot for the column below it
        if ((state_reg == S_FIN) && (phase_reg == PH_U) && (k_reg == i_reg))
            pivot_reg <= q_val;

        if ((state_reg == S_EMIT_WR) && out_free)
        begin
            out_value_reg    <= singular_reg ? 32'sd0 : sol_rdata_reg;
            out_index_reg    <= e_reg[2:0];
            out_last_reg     <= emit_last;
            out_singular_reg <= singular_reg;
        end
    end

    assign solution_valid = out_valid_reg;
    assign solution_value = out_value_reg;
    assign solution_index = out_index_reg;
    assign last           = out_last_reg;
    assign singular       = out_singular_reg;

    // ---------------------------------------------------------------- checks
`include "lu_linear_solver_assert.svh"

    `LU_ASSERT_IMP(a_div_only_waiting, clk, rst_n, div_done, state_reg == S_DIV)
    `LU_ASSERT_IMP(a_singular_zero, clk, rst_n, solution_valid && singular, solution_value == 32'sd0)
    `LU_ASSERT_NXT(a_emit_ends_load, clk, rst_n, (state_reg == S_EMIT_WR) && out_free && emit_last, state_reg == S_LOAD)

endmodule

/* tb/lu_linear_solver_test.sv */
// self-checking testbench for the doolittle lu solver: random and directed systems
// depends on lu_pkg and the lu_linear_solver rtl; expected solutions come from a
// fixed-point model of the factorization held in a small tracker class
`timescale 1ns / 1ps

module lu_linear_solver_test;

    localparam int FRAC   = 16;
    localparam int MAXN   = 8;
    localparam int ITEMS  = 160;
    localparam logic KIND_MATRIX = 1'b0;
    localparam logic KIND_RHS    = 1'b1;
    localparam logic [lu_pkg::CFG_AW-1:0] ADDR_SIZE = '0;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic kind = 1'b0;
    logic signed [31:0] value = '0;
    logic solution_valid;
    logic solution_stall = 1'b0;
    logic signed [31:0] solution_value;
    logic [2:0] solution_index;
    logic last;
    logic singular;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [lu_pkg::CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // idling on both sides, off during the quiet stretch
    bit idling_on = 1'b1;
    // one long hold-off of the receiver
    bit hold_req = 1'b0;
    int sent = 0;

    typedef struct {
        logic signed [31:0] sol;
        logic [2:0]         idx;
        logic               lst;
        logic               sing;
    } solution_t;

    class solve_tracker;
        logic [3:0] size_reg = 4'd8;
        int factor[MAXN*MAXN];
        int rhs[MAXN];
        int xs[MAXN];
        int mat_cnt = 0;
        int rhs_cnt = 0;
        solution_t pending_x[$];
        int errors = 0;

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        function int order();
            if (size_reg == 0) return 1;
            if (size_reg > MAXN) return MAXN;
            return size_reg;
        endfunction

        // floor shift back to q format, then saturate
        function int narrow(logic signed [127:0] acc);
            logic signed [127:0] s;
            s = acc >>> FRAC;
            if (s > 128'sd2147483647) return 32'h7fffffff;
            if (s < -128'sd2147483648) return 32'h80000000;
            return int'(s[31:0]);
        endfunction

        function logic signed [127:0] widen(int v);
            logic signed [127:0] a;
            a = v;
            return a <<< FRAC;
        endfunction

        function logic signed [127:0] less_prod(logic signed [127:0] acc, int a, int b);
            longint p;
            logic signed [127:0] pw;
            p = longint'(a) * longint'(b);
            pw = p;
            return acc - pw;
        endfunction

        function int qdiv(int num, int den);
            longint q;
            q = (longint'(num) <<< FRAC) / longint'(den);
            if (q > 64'sd2147483647) return 32'h7fffffff;
            if (q < -64'sd2147483648) return 32'h80000000;
            return int'(q);
        endfunction

        // in-place factorization and both substitutions; 1 when a pivot is zero
        function bit solve_system(int n);
            logic signed [127:0] acc;
            for (int i = 0; i < n; i++) begin
                for (int k = i; k < n; k++) begin
                    acc = widen(factor[i*n+k]);
                    for (int j = 0; j < i; j++)
                        acc = less_prod(acc, factor[i*n+j], factor[j*n+k]);
                    factor[i*n+k] = narrow(acc);
                end
                if (factor[i*n+i] == 0) return 1'b1;
                for (int k = i + 1; k < n; k++) begin
                    acc = widen(factor[k*n+i]);
                    for (int j = 0; j < i; j++)
                        acc = less_prod(acc, factor[k*n+j], factor[j*n+i]);
                    factor[k*n+i] = qdiv(narrow(acc), factor[i*n+i]);
                end
            end
            for (int i = 0; i < n; i++) begin
                acc = widen(rhs[i]);
                for (int j = 0; j < i; j++) acc = less_prod(acc, factor[i*n+j], xs[j]);
                xs[i] = narrow(acc);
            end
            for (int i = n - 1; i >= 0; i--) begin
                acc = widen(xs[i]);
                for (int j = i + 1; j < n; j++) acc = less_prod(acc, factor[i*n+j], xs[j]);
                xs[i] = qdiv(narrow(acc), factor[i*n+i]);
            end
            return 1'b0;
        endfunction

        function void take_item(logic k, logic signed [31:0] v);
            int n;
            bit sg;
            solution_t r;
            n = order();
            if (k == KIND_MATRIX) begin
                if (mat_cnt < n*n && mat_cnt < MAXN*MAXN) begin
                    factor[mat_cnt] = v;
                    mat_cnt++;
                end
                return;
            end
            if (mat_cnt < n*n) return;
            if (rhs_cnt < n) begin
                rhs[rhs_cnt] = v;
                rhs_cnt++;
            end
            if (rhs_cnt < n) return;
            sg = solve_system(n);
            for (int i = 0; i < n; i++) begin
                r.sol  = sg ? 32'sd0 : xs[i];
                r.idx  = 3'(i);
                r.lst  = (i == n - 1);
                r.sing = sg;
                pending_x = {pending_x, r};
            end
            mat_cnt = 0;
            rhs_cnt = 0;
        endfunction

        task match_result(solution_t got);
            solution_t w;
            if (pending_x.size() == 0) begin
                report($sformatf("unexpected solution index %0d", got.idx));
                return;
            end
            w = pending_x.pop_front();
            if (got.sol !== w.sol)
                report($sformatf("value %0h, wanted %0h", got.sol, w.sol));
            if (got.idx !== w.idx)
                report($sformatf("index %0d, wanted %0d", got.idx, w.idx));
            if (got.lst !== w.lst)
                report($sformatf("last %b, wanted %b", got.lst, w.lst));
            if (got.sing !== w.sing)
                report($sformatf("singular %b, wanted %b", got.sing, w.sing));
        endtask
    endclass

    solve_tracker book = new();

    lu_linear_solver dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .kind(kind), .value(value),
        .solution_valid(solution_valid), .solution_stall(solution_stall),
        .solution_value(solution_value), .solution_index(solution_index),
        .last(last), .singular(singular),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    // result side: check every accepted transaction against the oldest expectation
    always @(posedge clk) begin
        solution_t got;
        if (rst_n && solution_valid && !solution_stall) begin
            got.sol  = solution_value;
            got.idx  = solution_index;
            got.lst  = last;
            got.sing = singular;
            book.match_result(got);
        end
    end

    // receiver stall, with one long hold-off counted here
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge clk) begin
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            solution_stall <= 1'b1;
        end else begin
            solution_stall <= idling_on && ($urandom_range(99) < 36);
        end
    end

    // one transaction on the item channel; the model sees it at the accepting edge
    // valid stays high afterwards so that a following transaction can go back to back
    task send_item(logic k, logic signed [31:0] v);
        while (idling_on && $urandom_range(99) < 36) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        kind <= k;
        value <= v;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        book.take_item(k, v);
        sent++;
    endtask

    // apb write of the order, only once all solutions are out and the block has settled
    task write_size(logic [3:0] n);
        item_valid <= 1'b0;
        while (book.pending_x.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_SIZE;
        pwdata <= 32'(n);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        book.size_reg = n;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // mostly well-conditioned entries, now and then the full range
    function logic signed [31:0] pick_entry(bit diag, int n);
        if ($urandom_range(7) == 0) return $urandom;
        if (diag) return (n <<< FRAC) + $signed($urandom_range(65535)) - 32768;
        return $signed($urandom_range(131072)) - 65536;
    endfunction

    task random_system(int n);
        bit noisy;
        noisy = ($urandom_range(9) == 0);
        if (noisy) send_item(KIND_RHS, $urandom);        // early, ignored
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                send_item(KIND_MATRIX, pick_entry(r == c, n));
        if (noisy) send_item(KIND_MATRIX, $urandom);     // surplus, ignored
        for (int r = 0; r < n; r++)
            send_item(KIND_RHS, pick_entry(1'b0, n));
    endtask

    initial begin
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: order 1 with saturating extremes
        write_size(4'd1);
        send_item(KIND_MATRIX, 32'sh0000_0100);
        send_item(KIND_RHS, 32'sh7fff_ffff);
        send_item(KIND_MATRIX, 32'sh8000_0000);
        send_item(KIND_RHS, 32'sh8000_0000);
        // zero pivot
        send_item(KIND_MATRIX, 32'sh0);
        send_item(KIND_RHS, 32'sh0001_0000);
        // zero order behaves as one
        write_size(4'd0);
        send_item(KIND_MATRIX, 32'shffff_0000);
        send_item(KIND_RHS, 32'sh0003_0000);
        // order 2: early rhs ignored, surplus matrix element ignored
        write_size(4'd2);
        send_item(KIND_RHS, 32'sh1234_5678);
        send_item(KIND_MATRIX, 32'sh0002_0000);
        send_item(KIND_MATRIX, 32'sh0001_0000);
        send_item(KIND_MATRIX, 32'sh0001_0000);
        send_item(KIND_MATRIX, 32'sh0003_0000);
        send_item(KIND_MATRIX, 32'sh7fff_ffff);
        send_item(KIND_RHS, 32'sh0005_0000);
        send_item(KIND_RHS, 32'shfffb_0000);
        // order shrunk after one rhs element: the next rhs is dropped but solves
        send_item(KIND_MATRIX, 32'sh0004_0000);
        send_item(KIND_MATRIX, 32'sh0);
        send_item(KIND_MATRIX, 32'sh0);
        send_item(KIND_MATRIX, 32'sh0001_0000);
        send_item(KIND_RHS, 32'sh0008_0000);
        write_size(4'd1);
        send_item(KIND_RHS, 32'sh7777_7777);

        // one system at the top order, via an out-of-range setting, as the quiet stretch
        write_size(4'd15);
        idling_on = 1'b0;
        random_system(MAXN);
        idling_on = 1'b1;

        // random systems, mostly small; one long hold-off near the end
        while (sent < ITEMS - 15) begin
            if (sent > 120) hold_req = 1'b1;
            if (!hold_req && $urandom_range(2) == 0) begin
                n = $urandom_range(4, 0);
                write_size(4'(n));
            end
            random_system(book.order());
        end
        idling_on = 1'b1;
        hold_req = 1'b1;
        random_system(book.order());
        item_valid <= 1'b0;

        while (book.pending_x.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (book.pending_x.size() != 0) book.report("solutions never delivered");
        if (book.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
